>>> rtl/hrrn_pkg.sv
// Shared types and constants for the HRRN scheduler.
`default_nettype none
package hrrn_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic        op;
        logic [7:0]  proc_id;
        logic [31:0] arrival_time;
        logic [15:0] burst_length;
    } hrrn_in_t;

    typedef struct packed {
        logic       running_valid;
        logic [7:0] running_id;
        logic       arrival_dropped;
    } hrrn_out_t;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_ARRIVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_SCAN,
        ST_MUL,
        ST_CMP,
        ST_PICK,
        ST_DONE
    } hrrn_state_t;

endpackage
`default_nettype wire

>>> rtl/hrrn_fifo.sv
// Small queue used on both sides of the scheduling engine (input and result queues).
`default_nettype none
module hrrn_fifo
    import hrrn_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];

    // storage
    always_ff @(posedge clk) begin
        if (wr_en && !full) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en && !full) begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en && !empty) begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
        end
    end
endmodule
`default_nettype wire

>>> rtl/hrrn_engine.sv
// Scheduling engine: slot table, sequential ratio scan, job timing.
`default_nettype none
module hrrn_engine
    import hrrn_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_empty,
    input  wire hrrn_in_t  cmd,
    output logic           cmd_pop,
    input  wire logic      res_full,
    output logic           res_push,
    output hrrn_out_t      res
);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = SW + 1;

    // slot table
    logic          valid_reg [SLOTS];
    logic [7:0]    id_reg    [SLOTS];
    logic [31:0]   arr_reg   [SLOTS];
    logic [15:0]   burst_reg [SLOTS];
    logic [SW-1:0] age_reg   [SLOTS];

    logic [31:0] now_reg, now_next;
    logic        run_v_reg, run_v_next;
    logic [7:0]  run_id_reg, run_id_next;
    logic [15:0] rem_reg, rem_next;

    hrrn_state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          have_reg, have_next;
    logic [SW-1:0] best_reg, best_next;
    logic [32:0]   bnum_reg, bnum_next;
    logic [15:0]   bden_reg, bden_next;
    logic [48:0]   lhs_reg, rhs_reg;
    logic          drop_reg, drop_next;

    logic [SW-1:0] cur;
    logic [32:0]   cnum;
    logic          elig;

    // free slot and occupancy search
    logic [SW-1:0] free_idx;
    logic          free_found;
    logic [CW-1:0] count;
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        count      = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (valid_reg[i]) begin
                count = count + 1'b1;
            end else if (!free_found) begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    assign cur  = idx_reg[SW-1:0];
    assign elig = valid_reg[cur] && (arr_reg[cur] <= now_reg);
    assign cnum = {1'b0, now_reg - arr_reg[cur]} + 33'(burst_reg[cur]);

    // control
    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        have_next   = have_reg;
        best_next   = best_reg;
        bnum_next   = bnum_reg;
        bden_next   = bden_reg;
        drop_next   = drop_reg;
        now_next    = now_reg;
        run_v_next  = run_v_reg;
        run_id_next = run_id_reg;
        rem_next    = rem_reg;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!cmd_empty) begin
                    cmd_pop = 1'b1;
                    if (cmd.op == OP_ARRIVAL) begin
                        drop_next  = !free_found;
                        state_next = ST_ARRIVE;
                    end else if (run_v_reg) begin
                        drop_next = 1'b0;
                        rem_next  = rem_reg - 1'b1;
                        now_next  = now_reg + 1'b1;
                        if (rem_reg == 16'd1) begin
                            run_v_next  = 1'b0;
                            run_id_next = '0;
                        end
                        state_next = ST_DONE;
                    end else begin
                        drop_next  = 1'b0;
                        idx_next   = '0;
                        have_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_ARRIVE: state_next = ST_DONE;
            ST_SCAN: begin
                if (idx_reg == CW'(SLOTS)) begin
                    state_next = ST_PICK;
                end else if (!elig) begin
                    idx_next = idx_reg + 1'b1;
                end else if (!have_reg) begin
                    have_next = 1'b1;
                    best_next = cur;
                    bnum_next = cnum;
                    bden_next = burst_reg[cur];
                    idx_next  = idx_reg + 1'b1;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_CMP;
            ST_CMP: begin
                if (lhs_reg > rhs_reg ||
                    (lhs_reg == rhs_reg && age_reg[cur] < age_reg[best_reg])) begin
                    best_next = cur;
                    bnum_next = cnum;
                    bden_next = burst_reg[cur];
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SCAN;
            end
            ST_PICK: begin
                if (have_reg) begin
                    run_v_next  = 1'b1;
                    run_id_next = id_reg[best_reg];
                    rem_next    = burst_reg[best_reg];
                end else begin
                    now_next = now_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!res_full) begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign res.running_valid   = run_v_reg;
    assign res.running_id      = run_id_reg;
    assign res.arrival_dropped = drop_reg;

    // held arrival for the store cycle
    hrrn_in_t held_reg;
    logic [SW-1:0] slot_reg;
    logic [CW-1:0] cnt_reg;

    // ratio products, one register stage
    always_ff @(posedge clk) begin
        lhs_reg <= cnum[32:0] * bden_reg;
        rhs_reg <= bnum_reg * burst_reg[cur];
        if (state_reg == ST_IDLE) begin
            held_reg <= cmd;
            slot_reg <= free_idx;
            cnt_reg  <= count;
        end
    end

    // slot payload
    always_ff @(posedge clk) begin
        if (state_reg == ST_ARRIVE && !drop_reg) begin
            id_reg[slot_reg]    <= held_reg.proc_id;
            arr_reg[slot_reg]   <= held_reg.arrival_time;
            burst_reg[slot_reg] <= (held_reg.burst_length == '0) ? 16'd1
                                                                 : held_reg.burst_length;
            age_reg[slot_reg]   <= cnt_reg[SW-1:0];
        end else if (state_reg == ST_PICK && have_reg) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (valid_reg[i] && age_reg[i] > age_reg[best_reg]) begin
                    age_reg[i] <= age_reg[i] - 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            have_reg   <= 1'b0;
            best_reg   <= '0;
            bnum_reg   <= '0;
            bden_reg   <= 16'd1;
            drop_reg   <= 1'b0;
            now_reg    <= '0;
            run_v_reg  <= 1'b0;
            run_id_reg <= '0;
            rem_reg    <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            have_reg   <= have_next;
            best_reg   <= best_next;
            bnum_reg   <= bnum_next;
            bden_reg   <= bden_next;
            drop_reg   <= drop_next;
            now_reg    <= now_next;
            run_v_reg  <= run_v_next;
            run_id_reg <= run_id_next;
            rem_reg    <= rem_next;
            if (state_reg == ST_ARRIVE && !drop_reg) begin
                valid_reg[slot_reg] <= 1'b1;
            end else if (state_reg == ST_PICK && have_reg) begin
                valid_reg[best_reg] <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/hrrn_process_scheduler_unit.sv
// Top level: input queue, scheduling engine, result queue.
// Usage:
//   Input channel: push an item (op, proc_id, arrival_time, burst_length)
//   while full is low. Result channel: while empty is low the oldest result
//   (running_valid, running_id, arrival_dropped) is on res; pop takes it.
//   An arrival passes through ST_ARRIVE and ST_DONE in the engine, a tick
//   with a job running only through ST_DONE. A tick with nothing running
//   scans all SLOTS slots one at a time; each eligible slot after the first
//   goes through the product register (ST_MUL) and the compare (ST_CMP),
//   then ST_PICK chooses the job. The scan's single cross-multiply unit
//   sets the pace of the scan.
//   Two-entry queues on both sides let the producer keep pushing while a
//   result waits. If the receiver stalls, results back up in the output
//   queue and then the engine and input queue stall; nothing is lost.
//   Reset empties both queues, clears the slot table, the clock and the
//   running job.
`default_nettype none
module hrrn_process_scheduler_unit
    import hrrn_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire hrrn_in_t  item,
    output logic           full,
    input  wire logic      pop,
    output hrrn_out_t      res,
    output logic           empty
);
    logic      cmd_empty, cmd_pop, res_full, res_push;
    hrrn_in_t  cmd;
    hrrn_out_t eres;

    hrrn_fifo #(.WIDTH($bits(hrrn_in_t)), .DEPTH(FIFO_DEPTH)) u_in_q (
        .clk(clk), .rst_n(rst_n),
        .wr_en(push), .wr_data(item), .full(full),
        .rd_en(cmd_pop), .rd_data(cmd), .empty(cmd_empty)
    );

    hrrn_engine #(.SLOTS(SLOTS)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .cmd_empty(cmd_empty), .cmd(cmd), .cmd_pop(cmd_pop),
        .res_full(res_full), .res_push(res_push), .res(eres)
    );

    hrrn_fifo #(.WIDTH($bits(hrrn_out_t)), .DEPTH(FIFO_DEPTH)) u_out_q (
        .clk(clk), .rst_n(rst_n),
        .wr_en(res_push), .wr_data(eres), .full(res_full),
        .rd_en(pop), .rd_data(res), .empty(empty)
    );
endmodule
`default_nettype wire

>>> rtl/hrrn_checker.sv
// Port-level checks for the scheduler top level.
`default_nettype none
module hrrn_checker
    import hrrn_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      push,
    input wire logic      full,
    input wire logic      pop,
    input wire logic      empty,
    input wire hrrn_out_t res
);
    // an idle running flag carries no id
    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !res.running_valid) |-> (res.running_id == '0))
        else $error("running_id set without running job");

    // results never appear from nothing right after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result queue not empty after reset");

    // a waiting result is not changed until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(res)))
        else $error("waiting result changed");

    // the input queue fills only through a push
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");
endmodule

bind hrrn_process_scheduler_unit hrrn_checker u_chk (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .pop(pop), .empty(empty), .res(res)
);
`default_nettype wire
